### rtl/pcswl_pkg.sv
`timescale 1ns / 1ps

package pcswl_pkg;

  // Field widths of the channels and the configuration port.
  localparam int CODE_W     = 4;
  localparam int STAMP_W    = 40;
  localparam int WIN_W      = 32;
  localparam int LIM_W      = 4;
  localparam int INWIN_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Default sizing.
  localparam int DEF_SLOTS   = 8;
  localparam int DEF_CLASSES = 3;

  // Tracked event codes and the class that uses the special settings.
  localparam logic [CODE_W-1:0] CODE_PUBLISH = 4'd0;
  localparam logic [CODE_W-1:0] CODE_DELETE  = 4'd5;
  localparam logic [CODE_W-1:0] CODE_MODIFY  = 4'd6;
  localparam int MODIFY_CLASS = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WINDOW = 2'd3;

  // Register values after reset.
  localparam logic [LIM_W-1:0] RST_SPECIAL_LIMIT  = 4'd6;
  localparam logic [LIM_W-1:0] RST_DEFAULT_LIMIT  = 4'd5;
  localparam logic [WIN_W-1:0] RST_SPECIAL_WINDOW = 32'd60000;
  localparam logic [WIN_W-1:0] RST_DEFAULT_WINDOW = 32'd60000;

  typedef struct packed {
    logic       known;
    logic [2:0] idx;
  } class_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
    logic fetch;
    logic walk;
    logic step;
    logic commit;
    logic post;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic known;
    logic expire;
    logic out_free;
  } sts_t;

  // Map an event code onto its class slot.
  function automatic class_sel_t class_of(logic [CODE_W-1:0] code);
    class_sel_t sel;
    sel = '{known: 1'b0, idx: 3'd0};
    case (code)
      CODE_PUBLISH: sel = '{known: 1'b1, idx: 3'd0};
      CODE_DELETE:  sel = '{known: 1'b1, idx: 3'd1};
      CODE_MODIFY:  sel = '{known: 1'b1, idx: 3'd2};
      default:      sel = '{known: 1'b0, idx: 3'd0};
    endcase
    return sel;
  endfunction

endpackage

### rtl/pcswl_req_if.sv
`timescale 1ns / 1ps

interface pcswl_req_if;
  logic                          valid;
  logic                          ready;
  logic [pcswl_pkg::CODE_W-1:0]  event_code;
  logic [pcswl_pkg::STAMP_W-1:0] now_ms;

  modport source (output valid, event_code, now_ms, input ready);
  modport sink   (input valid, event_code, now_ms, output ready);
endinterface

### rtl/pcswl_rsp_if.sv
`timescale 1ns / 1ps

interface pcswl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          allowed;
  logic                          unknown_class;
  logic [pcswl_pkg::INWIN_W-1:0] in_window;

  modport source (output valid, allowed, unknown_class, in_window, input ready);
  modport sink   (input valid, allowed, unknown_class, in_window, output ready);
endinterface

### rtl/per_class_sliding_window_limiter.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields                                  Handshake
// req       in   event_code[3:0], now_ms[39:0]           req.valid / req.ready
// rsp       out  allowed, unknown_class, in_window[3:0]  rsp.valid / rsp.ready
// cfg       in   cfg_index[1:0], cfg_data[31:0]          cfg_we, no back-pressure
//
// A tracked word steps through load, fetch, the expiry walk, commit and done between
// acceptances; the walk drops the 0 to SLOTS stamps that expire, one stamp per cycle
// through the single read port of the stamp RAM. An unknown code goes from load to done.
// Reset (rst, synchronous) empties every class log and restores the register defaults.
// A finished word waits in the output register; the block takes a new word meanwhile,
// and stalls in its last step only when the next result is ready before rsp drains.
module per_class_sliding_window_limiter #(
  parameter int SLOTS   = pcswl_pkg::DEF_SLOTS,
  parameter int CLASSES = pcswl_pkg::DEF_CLASSES
) (
  input  logic                              clk,
  input  logic                              rst,
  pcswl_req_if.sink                         req,
  pcswl_rsp_if.source                       rsp,
  input  logic                              cfg_we,
  input  logic [pcswl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcswl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pcswl_pkg::cmd_t cmd;
  pcswl_pkg::sts_t sts;

  pcswl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcswl_dpath #(
    .SLOTS   (SLOTS),
    .CLASSES (CLASSES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .event_code    (req.event_code),
    .now_ms        (req.now_ms),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .allowed       (rsp.allowed),
    .unknown_class (rsp.unknown_class),
    .in_window     (rsp.in_window),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

endmodule

### rtl/pcswl_ram.sv
`timescale 1ns / 1ps

module pcswl_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 24,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pcswl_ctrl.sv
`timescale 1ns / 1ps

module pcswl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcswl_pkg::sts_t   sts,
  output pcswl_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Sequencing of one word: load class state, walk the expired entries, commit, post; unknown codes skip to post.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = sts.known ? S_FETCH : S_DONE;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.expire) begin
          cmd.step = 1'b1;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LOAD))
    else $error("accepted word did not start a class load");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && !sts.expire) |=> (state == S_COMMIT))
    else $error("expiry walk did not end in commit");

endmodule

### rtl/pcswl_dpath.sv
`timescale 1ns / 1ps

module pcswl_dpath #(
  parameter int SLOTS   = pcswl_pkg::DEF_SLOTS,
  parameter int CLASSES = pcswl_pkg::DEF_CLASSES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pcswl_pkg::cmd_t                   cmd,
  output pcswl_pkg::sts_t                   sts,
  input  logic [pcswl_pkg::CODE_W-1:0]      event_code,
  input  logic [pcswl_pkg::STAMP_W-1:0]     now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              allowed,
  output logic                              unknown_class,
  output logic [pcswl_pkg::INWIN_W-1:0]     in_window,
  input  logic                              cfg_we,
  input  logic [pcswl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcswl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int KW    = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int DEPTH = CLASSES * SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers.
  logic [pcswl_pkg::LIM_W-1:0] special_limit;
  logic [pcswl_pkg::LIM_W-1:0] default_limit;
  logic [pcswl_pkg::WIN_W-1:0] special_window_ms;
  logic [pcswl_pkg::WIN_W-1:0] default_window_ms;

  // Per-class ring pointers and fill counts.
  logic [SW-1:0] oldest_slot [CLASSES];
  logic [CW-1:0] held_count  [CLASSES];

  // Working registers of the word in flight.
  logic [pcswl_pkg::CODE_W-1:0]  code_q;
  logic [pcswl_pkg::STAMP_W-1:0] now_q;
  logic [KW-1:0]                 cls;
  logic [SW-1:0]                 head;
  logic [CW-1:0]                 cnt;
  logic [CW-1:0]                 lim;
  logic [pcswl_pkg::WIN_W-1:0]   win;
  logic                          res_allowed;
  logic                          res_unknown;
  logic [pcswl_pkg::INWIN_W-1:0] res_in_window;

  pcswl_pkg::class_sel_t         sel;
  logic                          known_c;
  logic [KW-1:0]                 cls_c;
  logic                          modify_c;
  logic [pcswl_pkg::LIM_W-1:0]   lim_raw;
  logic [AW-1:0]                 base;
  logic [SW-1:0]                 head_inc;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 wr_addr;
  logic [pcswl_pkg::STAMP_W-1:0] stamp;
  logic [pcswl_pkg::STAMP_W-1:0] diff;
  logic                          admit;
  logic [CW-1:0]                 cnt_new;
  logic [7:0]                    tail_sum;
  logic [SW-1:0]                 tail;
  logic [7:0]                    cnt_wide;

  // Class decode of the held event code.
  always_comb begin
    sel      = pcswl_pkg::class_of(code_q);
    known_c  = sel.known && ({29'd0, sel.idx} < 32'(CLASSES));
    cls_c    = KW'(sel.idx);
    modify_c = (32'(cls_c) == 32'(pcswl_pkg::MODIFY_CLASS));
    lim_raw  = modify_c ? special_limit : default_limit;
  end

  // Ring addressing: the walk reads one slot ahead of the head.
  always_comb begin
    base     = AW'(32'(cls) * SLOTS);
    head_inc = (head == SW'(SLOTS - 1)) ? '0 : head + SW'(1);
    rd_addr  = base + AW'(cmd.walk ? head_inc : head);
    tail_sum = 8'(head) + 8'(cnt);
    if (tail_sum >= 8'(SLOTS)) begin
      tail_sum = tail_sum - 8'(SLOTS);
    end
    tail     = SW'(tail_sum);
    wr_addr  = base + AW'(tail);
  end

  // Expiry test on the oldest held stamp, and the admission decision.
  always_comb begin
    diff       = (now_q >= stamp) ? (now_q - stamp) : (stamp - now_q);
    sts.known  = known_c;
    sts.expire = (cnt != '0) && (diff > {8'd0, win});
    sts.out_free = !out_valid || out_ready;
    admit      = (cnt < lim);
    cnt_new    = admit ? cnt + CW'(1) : cnt;
    cnt_wide   = 8'(cnt_new);
  end

  pcswl_ram #(
    .WIDTH (pcswl_pkg::STAMP_W),
    .DEPTH (DEPTH)
  ) u_stamps (
    .clk   (clk),
    .we    (cmd.commit && admit),
    .waddr (wr_addr),
    .wdata (now_q),
    .raddr (rd_addr),
    .rdata (stamp)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      special_limit     <= pcswl_pkg::RST_SPECIAL_LIMIT;
      default_limit     <= pcswl_pkg::RST_DEFAULT_LIMIT;
      special_window_ms <= pcswl_pkg::RST_SPECIAL_WINDOW;
      default_window_ms <= pcswl_pkg::RST_DEFAULT_WINDOW;
    end else if (cfg_we) begin
      case (cfg_index)
        pcswl_pkg::CFG_SPECIAL_LIMIT:  special_limit     <= cfg_data[pcswl_pkg::LIM_W-1:0];
        pcswl_pkg::CFG_DEFAULT_LIMIT:  default_limit     <= cfg_data[pcswl_pkg::LIM_W-1:0];
        pcswl_pkg::CFG_SPECIAL_WINDOW: special_window_ms <= cfg_data;
        pcswl_pkg::CFG_DEFAULT_WINDOW: default_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-class state: updated once per tracked word at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLASSES; i++) begin
        oldest_slot[i] <= '0;
        held_count[i]  <= '0;
      end
    end else if (cmd.commit) begin
      oldest_slot[cls] <= head;
      held_count[cls]  <= cnt_new;
    end
  end

  // Working registers of the word in flight.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      code_q <= event_code;
      now_q  <= now_ms;
    end
    if (cmd.load) begin
      cls           <= cls_c;
      head          <= oldest_slot[cls_c];
      cnt           <= held_count[cls_c];
      lim           <= ({4'd0, lim_raw} > 8'(SLOTS)) ? CW'(SLOTS) : CW'(lim_raw);
      win           <= modify_c ? special_window_ms : default_window_ms;
      res_allowed   <= 1'b0;
      res_unknown   <= !known_c;
      res_in_window <= '0;
    end
    if (cmd.step) begin
      head <= head_inc;
      cnt  <= cnt - CW'(1);
    end
    if (cmd.commit) begin
      cnt           <= cnt_new;
      res_allowed   <= admit;
      res_in_window <= cnt_wide[pcswl_pkg::INWIN_W-1:0];
    end
  end

  // Output register: holds a finished word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      allowed       <= res_allowed;
      unknown_class <= res_unknown;
      in_window     <= res_in_window;
    end
  end

  a_step_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (cnt != '0))
    else $error("expiry step on an empty log");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit || cmd.step) |-> (32'(cnt) <= 32'(SLOTS)))
    else $error("held count above the slot count");

  a_post_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.post |=> out_valid)
    else $error("posted word not presented");

endmodule

### verif/per_class_sliding_window_limiter_tb.sv
`timescale 1ns / 1ps

module per_class_sliding_window_limiter_tb;

  localparam int SLOT_N          = pcswl_pkg::DEF_SLOTS;
  localparam int CLASS_N         = pcswl_pkg::DEF_CLASSES;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 210;
  localparam int SETTLE_CYCLES   = 20;
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int MAX_REPORTS     = 40;
  localparam int BACKLOG_DEPTH   = 4096;

  typedef struct packed {
    logic [pcswl_pkg::CODE_W-1:0]  code;
    logic [pcswl_pkg::STAMP_W-1:0] stamp;
  } event_word_t;

  typedef struct packed {
    logic                          allowed;
    logic                          unknown_class;
    logic [pcswl_pkg::INWIN_W-1:0] in_window;
  } verdict_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we;
  logic [pcswl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pcswl_pkg::CFG_DATA_W-1:0] cfg_data;

  pcswl_req_if req_ch ();
  pcswl_rsp_if rsp_ch ();

  per_class_sliding_window_limiter dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies kept by the predictor.
  logic [pcswl_pkg::LIM_W-1:0] lim_special = pcswl_pkg::RST_SPECIAL_LIMIT;
  logic [pcswl_pkg::LIM_W-1:0] lim_default = pcswl_pkg::RST_DEFAULT_LIMIT;
  logic [pcswl_pkg::WIN_W-1:0] win_special = pcswl_pkg::RST_SPECIAL_WINDOW;
  logic [pcswl_pkg::WIN_W-1:0] win_default = pcswl_pkg::RST_DEFAULT_WINDOW;

  // Per-class admission logs kept by the predictor.
  logic [pcswl_pkg::STAMP_W-1:0] stamp_log [CLASS_N][SLOT_N];
  int unsigned                   log_head  [CLASS_N];
  int unsigned                   log_count [CLASS_N];

  // Running time base per class for stimulus generation.
  logic [pcswl_pkg::STAMP_W-1:0] class_clock [CLASS_N];

  // Pending words and expected verdicts, each a ring with write and read counts.
  event_word_t event_backlog [BACKLOG_DEPTH];
  int          backlog_wr = 0;
  int          backlog_rd = 0;
  verdict_t    verdict_due [BACKLOG_DEPTH];
  int          due_wr = 0;
  int          due_rd = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go  = 1'b0;
  logic        hold_rsp = 1'b0;

  int errors          = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int admitted_cnt    = 0;
  int refused_cnt     = 0;
  int unknown_cnt     = 0;
  int settings_cnt    = 1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Work out the verdict for one event and update the class log.
  function automatic verdict_t admit_event(event_word_t w);
    verdict_t                      v;
    int                            cls;
    int unsigned                   lim;
    int unsigned                   head;
    int unsigned                   cnt;
    logic [pcswl_pkg::WIN_W-1:0]   win;
    logic [pcswl_pkg::STAMP_W-1:0] stored;
    logic [pcswl_pkg::STAMP_W-1:0] gap;
    v = '0;
    case (w.code)
      pcswl_pkg::CODE_PUBLISH: cls = 0;
      pcswl_pkg::CODE_DELETE:  cls = 1;
      pcswl_pkg::CODE_MODIFY:  cls = pcswl_pkg::MODIFY_CLASS;
      default:                 cls = -1;
    endcase
    if (cls < 0) begin
      v.unknown_class = 1'b1;
    end else begin
      lim = (cls == pcswl_pkg::MODIFY_CLASS) ? lim_special : lim_default;
      win = (cls == pcswl_pkg::MODIFY_CLASS) ? win_special : win_default;
      if (lim > SLOT_N) lim = SLOT_N;
      head = log_head[cls];
      cnt  = log_count[cls];
      // Drop stamps from the oldest end until one falls inside the window.
      while (cnt > 0) begin
        stored = stamp_log[cls][head];
        gap = (w.stamp >= stored) ? w.stamp - stored : stored - w.stamp;
        if (gap <= {{(pcswl_pkg::STAMP_W-pcswl_pkg::WIN_W){1'b0}}, win}) break;
        head = (head + 1) % SLOT_N;
        cnt--;
      end
      if (cnt < lim) begin
        stamp_log[cls][(head + cnt) % SLOT_N] = w.stamp;
        cnt++;
        v.allowed = 1'b1;
      end
      log_head[cls]  = head;
      log_count[cls] = cnt;
      v.in_window    = cnt[pcswl_pkg::INWIN_W-1:0];
    end
    return v;
  endfunction

  function automatic logic [pcswl_pkg::STAMP_W-1:0] rand_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[pcswl_pkg::STAMP_W-1:0];
  endfunction

  // Next time for a class: mostly small steps, repeats, jumps right at the
  // window edge in both directions, and now and then anywhere at all.
  function automatic logic [pcswl_pkg::STAMP_W-1:0] next_stamp(int cls);
    logic [pcswl_pkg::STAMP_W-1:0] win;
    logic [pcswl_pkg::STAMP_W-1:0] span;
    int unsigned                   r;
    win  = (cls == pcswl_pkg::MODIFY_CLASS) ? win_special : win_default;
    span = win / 4 + 1;
    r    = $urandom_range(99);
    if (r < 50)
      class_clock[cls] = class_clock[cls] + rand_stamp() % span;
    else if (r < 65)
      class_clock[cls] = class_clock[cls];
    else if (r < 80)
      class_clock[cls] = class_clock[cls] + win + $urandom_range(1);
    else if (r < 88)
      class_clock[cls] = class_clock[cls] - rand_stamp() % span;
    else if (r < 94)
      class_clock[cls] = class_clock[cls] - win - $urandom_range(1);
    else
      class_clock[cls] = rand_stamp();
    return class_clock[cls];
  endfunction

  function automatic logic [pcswl_pkg::LIM_W-1:0] random_limit();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return pcswl_pkg::LIM_W'($urandom_range(15, SLOT_N + 1));
    return pcswl_pkg::LIM_W'($urandom_range(SLOT_N, 1));
  endfunction

  function automatic logic [pcswl_pkg::WIN_W-1:0] random_window();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(100000, 1);
    endcase
  endfunction

  function automatic void push_event(logic [pcswl_pkg::CODE_W-1:0] code,
                                     logic [pcswl_pkg::STAMP_W-1:0] stamp);
    event_backlog[backlog_wr % BACKLOG_DEPTH] = '{code: code, stamp: stamp};
    backlog_wr++;
  endfunction

  task automatic queue_random_events(int count);
    int cls;
    repeat (count) begin
      if ($urandom_range(99) < 85) begin
        cls = $urandom_range(CLASS_N - 1);
        case (cls)
          0:       push_event(pcswl_pkg::CODE_PUBLISH, next_stamp(cls));
          1:       push_event(pcswl_pkg::CODE_DELETE, next_stamp(cls));
          default: push_event(pcswl_pkg::CODE_MODIFY, next_stamp(cls));
        endcase
      end else begin
        push_event(pcswl_pkg::CODE_W'($urandom_range(15)), rand_stamp());
      end
    end
  endtask

  // One register write; the predictor copy follows it.
  task automatic set_register(logic [pcswl_pkg::CFG_IDX_W-1:0] idx,
                              logic [pcswl_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      pcswl_pkg::CFG_SPECIAL_LIMIT:  lim_special = value[pcswl_pkg::LIM_W-1:0];
      pcswl_pkg::CFG_DEFAULT_LIMIT:  lim_default = value[pcswl_pkg::LIM_W-1:0];
      pcswl_pkg::CFG_SPECIAL_WINDOW: win_special = value[pcswl_pkg::WIN_W-1:0];
      pcswl_pkg::CFG_DEFAULT_WINDOW: win_default = value[pcswl_pkg::WIN_W-1:0];
      default: ;
    endcase
  endtask

  // Limits go out with random upper data bits, which the block must drop.
  task automatic configure(logic [pcswl_pkg::LIM_W-1:0] ls, logic [pcswl_pkg::LIM_W-1:0] ld,
                           logic [pcswl_pkg::WIN_W-1:0] ws, logic [pcswl_pkg::WIN_W-1:0] wd);
    logic [pcswl_pkg::CFG_DATA_W-1:0] junk;
    junk = $urandom;
    set_register(pcswl_pkg::CFG_SPECIAL_LIMIT,
                 {junk[pcswl_pkg::CFG_DATA_W-1:pcswl_pkg::LIM_W], ls});
    junk = $urandom;
    set_register(pcswl_pkg::CFG_DEFAULT_LIMIT,
                 {junk[pcswl_pkg::CFG_DATA_W-1:pcswl_pkg::LIM_W], ld});
    set_register(pcswl_pkg::CFG_SPECIAL_WINDOW, ws);
    set_register(pcswl_pkg::CFG_DEFAULT_WINDOW, wd);
    settings_cnt++;
  endtask

  // Wait until every word has gone in and every verdict has come back.
  task automatic wait_quiet();
    do @(negedge clk);
    while (backlog_wr != backlog_rd || req_ch.valid || due_wr != due_rd);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Driver: offers words from the backlog and predicts each accepted one.
  always @(posedge clk) begin : event_driver
    logic        offer;
    event_word_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      offer = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        verdict_due[due_wr % BACKLOG_DEPTH] =
          admit_event('{code: req_ch.event_code, stamp: req_ch.now_ms});
        due_wr++;
        words_sent++;
        offer = 1'b0;
      end
      if (!offer && backlog_wr != backlog_rd && $urandom_range(99) >= send_idle_pct) begin
        w = event_backlog[backlog_rd % BACKLOG_DEPTH];
        backlog_rd++;
        req_ch.event_code <= w.code;
        req_ch.now_ms     <= w.stamp;
        offer = 1'b1;
      end
      req_ch.valid <= offer;
    end
  end

  // Monitor: checks each returned word against the oldest prediction.
  always @(posedge clk) begin : verdict_monitor
    verdict_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_checked++;
        if (due_wr == due_rd) begin
          errors++;
          $display("%0t ns: result with nothing expected, actual allowed %0d unknown %0d count %0d",
                   $time, rsp_ch.allowed, rsp_ch.unknown_class, rsp_ch.in_window);
        end else begin
          want = verdict_due[due_rd % BACKLOG_DEPTH];
          due_rd++;
          check_field("allowed", want.allowed, rsp_ch.allowed);
          check_field("unknown_class", want.unknown_class, rsp_ch.unknown_class);
          check_field("in_window", want.in_window, rsp_ch.in_window);
          if (want.unknown_class) unknown_cnt++;
          else if (want.allowed) admitted_cnt++;
          else refused_cnt++;
        end
      end
      rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long response hold-off, counted here, so that the block backs up.
  initial begin : rsp_hold
    wait (hold_go);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (RSP_HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    req_ch.valid      = 1'b0;
    req_ch.event_code = '0;
    req_ch.now_ms     = '0;
    rsp_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    for (int c = 0; c < CLASS_N; c++) begin
      log_head[c]    = 0;
      log_count[c]   = 0;
      class_clock[c] = rand_stamp();
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part on the reset settings: fill the default class to its limit,
    // hit the window edge exactly and one past it, run time backwards from the
    // top of the range, fill the modify class, and send unknown codes.
    for (int t = 0; t < 50; t += 10) push_event(pcswl_pkg::CODE_PUBLISH, t);
    push_event(pcswl_pkg::CODE_PUBLISH, 50);
    push_event(pcswl_pkg::CODE_PUBLISH, 60000);
    push_event(pcswl_pkg::CODE_PUBLISH, 60001);
    push_event(pcswl_pkg::CODE_DELETE, '1);
    push_event(pcswl_pkg::CODE_DELETE, '0);
    repeat (7) push_event(pcswl_pkg::CODE_MODIFY, 5000);
    push_event(4'd1, 123);
    push_event(4'd15, '1);
    push_event(4'd7, 0);
    push_event(4'd4, 40'h55_5555_5555);
    push_event(pcswl_pkg::CODE_MODIFY, 65001);
    push_event(pcswl_pkg::CODE_MODIFY, 0);
    wait_quiet();

    // Random part, one register setting and one idling pattern per phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       configure(4'd8, 4'd1, '0, '1);
        1:       configure(4'd1, 4'd8, '1, '0);
        2:       configure(4'd0, 4'd15, 32'd1000, 32'd50);
        3:       configure(4'd15, 4'd0, 32'd50, 32'd1000);
        4:       configure(4'd3, 4'd4, 32'd60000, 32'd60000);
        default: configure(random_limit(), random_limit(), random_window(), random_window());
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
        end
      endcase
      if (phase == 4) hold_go = 1'b1;
      queue_random_events(WORDS_PER_PHASE);
      wait_quiet();
    end

    $display("Sent %0d events under %0d register settings: %0d admitted, %0d refused, %0d unknown.",
             words_sent, settings_cnt, admitted_cnt, refused_cnt, unknown_cnt);
    $display("Checked %0d results, %0d mismatches.", results_checked, errors);
    if (errors == 0 && due_wr == due_rd) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pcswl_pkg.sv
rtl/pcswl_req_if.sv
rtl/pcswl_rsp_if.sv
rtl/pcswl_ram.sv
rtl/pcswl_ctrl.sv
rtl/pcswl_dpath.sv
rtl/per_class_sliding_window_limiter.sv
verif/per_class_sliding_window_limiter_tb.sv
